### src/rpa_pkg.sv
package rpa_pkg;

  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_SHIFT = 12;
  localparam int COUNT_BITS = 8;

  localparam int ADDR_W    = 39;
  localparam int REG_W     = 27;
  localparam int OUT_CNT_W = 8;
  localparam int PFN_W     = ADDR_W - PAGE_SHIFT;
  localparam int CMP_W     = ((PFN_W > REG_W) ? PFN_W : REG_W) + 1;
  localparam int PN_W      = $clog2(NUM_PAGES);
  localparam int FC_W      = $clog2(NUM_PAGES + 1);
  localparam int CNT_W     = COUNT_BITS;
  localparam int CFG_IDX_W = 2;

  // depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOP  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_SEED   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_ADDREF = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BADADDR   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_NOMEM     = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef struct packed {
    op_t             op;
    logic            bad;
    logic [PN_W-1:0] pn;
  } entry_t;

endpackage

### src/rpa_req_if.sv
interface rpa_req_if;
  logic                       valid;
  logic                       ready;
  rpa_pkg::op_t               op;
  logic [rpa_pkg::ADDR_W-1:0] addr;

  modport source(output valid, op, addr, input ready);
  modport sink(input valid, op, addr, output ready);
endinterface

### src/rpa_rsp_if.sv
interface rpa_rsp_if;
  logic                          valid;
  logic                          ready;
  rpa_pkg::status_t              status;
  logic [rpa_pkg::ADDR_W-1:0]    page_addr;
  logic [rpa_pkg::OUT_CNT_W-1:0] ref_count;
  logic                          page_released;

  modport source(output valid, status, page_addr, ref_count, page_released, input ready);
  modport sink(input valid, status, page_addr, ref_count, page_released, output ready);
endinterface

### src/rpa_cfg_if.sv
interface rpa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rpa_pkg::CFG_IDX_W-1:0] index;
  logic [rpa_pkg::REG_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/rpa_front.sv
module rpa_front (
  input  logic             clk,
  input  logic             rst,
  rpa_req_if.sink          req,
  rpa_cfg_if.sink          cfg,
  input  logic             clearing,
  input  logic             q_full,
  output logic             q_push,
  output rpa_pkg::entry_t  q_din
);

  logic [rpa_pkg::REG_W-1:0] base_page;
  logic [rpa_pkg::REG_W-1:0] top_page;

  logic [rpa_pkg::PFN_W-1:0] pfn;
  logic [rpa_pkg::CMP_W-1:0] pfn_x;
  logic [rpa_pkg::CMP_W-1:0] base_x;
  logic [rpa_pkg::CMP_W-1:0] top_x;
  logic                      misaligned;
  logic                      out_of_range;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page <= '0;
      top_page  <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == rpa_pkg::CFG_BASE) begin
        base_page <= cfg.data;
      end
      if (cfg.index == rpa_pkg::CFG_TOP) begin
        top_page <= cfg.data;
      end
    end
  end

  assign pfn        = req.addr[rpa_pkg::ADDR_W-1:rpa_pkg::PAGE_SHIFT];
  assign pfn_x      = rpa_pkg::CMP_W'(pfn);
  assign base_x     = rpa_pkg::CMP_W'(base_page);
  assign top_x      = rpa_pkg::CMP_W'(top_page);
  assign misaligned = |req.addr[rpa_pkg::PAGE_SHIFT-1:0];
  assign out_of_range = (pfn_x < base_x) || (pfn_x >= top_x) ||
                        (pfn_x >= rpa_pkg::CMP_W'(rpa_pkg::NUM_PAGES));

  assign req.ready = !q_full && !clearing;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    q_din.op  = req.op;
    q_din.bad = (req.op != rpa_pkg::OP_ALLOC) && (misaligned || out_of_range);
    q_din.pn  = pfn[rpa_pkg::PN_W-1:0];
  end

endmodule

### src/rpa_queue.sv
module rpa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rpa_pkg::entry_t  din,
  output logic             full,
  input  logic             pop,
  output rpa_pkg::entry_t  head,
  output logic             empty
);

  rpa_pkg::entry_t                slots [rpa_pkg::QUEUE_DEPTH];
  logic [rpa_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rpa_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rpa_pkg::QCNT_W-1:0]     fill;

  assign full  = (fill == rpa_pkg::QCNT_W'(rpa_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/rpa_back.sv
module rpa_back (
  input  logic             clk,
  input  logic             rst,
  input  rpa_pkg::entry_t  head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             clearing,
  rpa_rsp_if.source        rsp
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_STK   = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  localparam logic [rpa_pkg::CNT_W-1:0] COUNT_MAX = '1;

  state_t state;
  state_t state_next;

  logic [rpa_pkg::PN_W-1:0]  clr_idx;
  logic [rpa_pkg::FC_W-1:0]  fc;
  logic [rpa_pkg::FC_W-1:0]  fc_next;
  logic [rpa_pkg::FC_W-1:0]  fc_dec;
  logic                      stack_full;

  rpa_pkg::op_t              cur_op;
  logic                      cur_bad;
  logic [rpa_pkg::PN_W-1:0]  cur_pn;

  logic [rpa_pkg::CNT_W-1:0] ref_mem [rpa_pkg::NUM_PAGES];
  logic [rpa_pkg::PN_W-1:0]  stack_mem [rpa_pkg::NUM_PAGES];

  logic                      ref_we;
  logic [rpa_pkg::PN_W-1:0]  ref_wa;
  logic [rpa_pkg::CNT_W-1:0] ref_wd;
  logic                      ref_re;
  logic [rpa_pkg::PN_W-1:0]  ref_ra;
  logic [rpa_pkg::CNT_W-1:0] ref_rd;

  logic                      stk_we;
  logic                      stk_re;
  logic [rpa_pkg::PN_W-1:0]  stk_ra;
  logic [rpa_pkg::PN_W-1:0]  stk_rd;

  logic                      fire;
  logic                      out_valid;
  rpa_pkg::status_t          out_status;
  logic [rpa_pkg::ADDR_W-1:0]    out_paddr;
  logic [rpa_pkg::OUT_CNT_W-1:0] out_cnt;
  logic                          out_rel;

  rpa_pkg::status_t              res_status;
  logic [rpa_pkg::ADDR_W-1:0]    res_paddr;
  logic [rpa_pkg::CNT_W-1:0]     res_cnt;
  logic                          res_rel;

  assign clearing   = (state == S_CLEAR);
  assign fc_dec     = fc - 1'b1;
  assign stack_full = (fc == rpa_pkg::FC_W'(rpa_pkg::NUM_PAGES));
  assign fire       = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign q_pop      = (state == S_IDLE) && !q_empty;

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.page_addr     = out_paddr;
  assign rsp.ref_count     = out_cnt;
  assign rsp.page_released = out_rel;

  always_comb begin
    res_status = rpa_pkg::ST_OK;
    res_paddr  = '0;
    res_cnt    = '0;
    res_rel    = 1'b0;
    ref_we     = 1'b0;
    ref_wa     = cur_pn;
    ref_wd     = '0;
    stk_we     = 1'b0;
    fc_next    = fc;
    if (state == S_CLEAR) begin
      ref_we = 1'b1;
      ref_wa = clr_idx;
    end else if (state == S_EXEC) begin
      if (cur_op == rpa_pkg::OP_ALLOC) begin
        if (fc == '0) begin
          res_status = rpa_pkg::ST_NOMEM;
        end else if (ref_rd != '0) begin
          res_status = rpa_pkg::ST_CORRUPT;
          res_cnt    = ref_rd;
        end else begin
          ref_we    = 1'b1;
          ref_wd    = rpa_pkg::CNT_W'(1);
          fc_next   = fc_dec;
          res_paddr = rpa_pkg::ADDR_W'(cur_pn) << rpa_pkg::PAGE_SHIFT;
          res_cnt   = rpa_pkg::CNT_W'(1);
        end
      end else if (cur_bad) begin
        res_status = rpa_pkg::ST_BADADDR;
      end else begin
        case (cur_op)
          rpa_pkg::OP_SEED: begin
            if (stack_full) begin
              res_status = rpa_pkg::ST_OVERFLOW;
              res_cnt    = ref_rd;
            end else begin
              ref_we  = 1'b1;
              ref_wd  = '0;
              stk_we  = 1'b1;
              fc_next = fc + 1'b1;
              res_rel = 1'b1;
            end
          end
          rpa_pkg::OP_FREE: begin
            if (ref_rd == '0) begin
              res_status = rpa_pkg::ST_UNDERFLOW;
            end else if (ref_rd == rpa_pkg::CNT_W'(1) && stack_full) begin
              res_status = rpa_pkg::ST_OVERFLOW;
              res_cnt    = ref_rd;
            end else begin
              ref_we  = 1'b1;
              ref_wd  = ref_rd - 1'b1;
              res_cnt = ref_rd - 1'b1;
              if (ref_rd == rpa_pkg::CNT_W'(1)) begin
                stk_we  = 1'b1;
                fc_next = fc + 1'b1;
                res_rel = 1'b1;
              end
            end
          end
          default: begin
            if (ref_rd == '0) begin
              res_status = rpa_pkg::ST_UNDERFLOW;
            end else if (ref_rd == COUNT_MAX) begin
              res_status = rpa_pkg::ST_OVERFLOW;
              res_cnt    = ref_rd;
            end else begin
              ref_we  = 1'b1;
              ref_wd  = ref_rd + 1'b1;
              res_cnt = ref_rd + 1'b1;
            end
          end
        endcase
      end
      if (!fire) begin
        ref_we  = 1'b0;
        stk_we  = 1'b0;
        fc_next = fc;
      end
    end
  end

  // read issue
  always_comb begin
    state_next = state;
    ref_re     = 1'b0;
    ref_ra     = head.pn;
    stk_re     = 1'b0;
    stk_ra     = fc_dec[rpa_pkg::PN_W-1:0];
    case (state)
      S_CLEAR: begin
        if (clr_idx == rpa_pkg::PN_W'(rpa_pkg::NUM_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          if (head.op == rpa_pkg::OP_ALLOC) begin
            if (fc != '0) begin
              stk_re     = 1'b1;
              state_next = S_STK;
            end else begin
              state_next = S_EXEC;
            end
          end else begin
            ref_re     = !head.bad;
            state_next = S_EXEC;
          end
        end
      end
      S_STK: begin
        ref_re     = 1'b1;
        ref_ra     = stk_rd;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (ref_re) begin
      ref_rd <= ref_mem[ref_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[fc[rpa_pkg::PN_W-1:0]] <= cur_pn;
    end
    if (stk_re) begin
      stk_rd <= stack_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op  <= head.op;
      cur_bad <= head.bad;
      cur_pn  <= head.pn;
    end else if (state == S_STK) begin
      cur_pn <= stk_rd;
    end
    if (fire) begin
      out_status <= res_status;
      out_paddr  <= res_paddr;
      out_cnt    <= rpa_pkg::OUT_CNT_W'(res_cnt);
      out_rel    <= res_rel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      fc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fc    <= fc_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    fire |=> (state == S_IDLE))
    else $error("engine did not return to idle after a result");

  a_fc_stable: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(fc))
    else $error("free count changed without a completed item");

  a_rise_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result appeared outside the execute step");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!out_valid && !q_pop))
    else $error("activity during the table clearing pass");

endmodule

### src/refcounted_page_allocator.sv
// An item is popped and its count table read issued, then it executes;
// allocate with a free page reads the stack top, then the count table.
// One item is in the engine at a time, bounded by the registered read and
// the write on the count table and stack; it waits while a result is held.
// Reset: synchronous; the count table is cleared over all NUM_PAGES (32768)
// entries after reset, during which no item is accepted.
module refcounted_page_allocator (
  input  logic       clk,
  input  logic       rst,
  rpa_req_if.sink    req,
  rpa_rsp_if.source  rsp,
  rpa_cfg_if.sink    cfg
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic             clearing;
  rpa_pkg::entry_t  q_din;
  rpa_pkg::entry_t  q_head;

  rpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  rpa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  rpa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule
